// ----- hw/rtl/boxds_pkg.sv -----
// Shared types and constants for the box average downscaler.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package boxds_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int SCALE_W    = 5;
    localparam int DIM_W      = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_BITS     = 8;
    localparam int STEP_W     = 3;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET  = 5'd2;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic merge;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic block_done;
        logic emit;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/box_average_downscaler.sv -----
// Box average downscaler: a pixel that does not end a block is only accepted; one
// that ends a block outside the last row of its band adds a line store merge.
// A pixel that completes a block in the last row of its band goes through merge,
// 8 restoring divider steps and output load; the output load waits while a held
// result still blocks the output register.
// Reset: scale 2, width 640, height 480, frame position zero; the line store is
// not cleared, since the first row of every band writes an entry before any read.
`timescale 1ns / 1ps

module box_average_downscaler #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [boxds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [boxds_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input channel
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [boxds_pkg::PIX_W-1:0]       pixel,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [boxds_pkg::PIX_W-1:0]       out_pixel,
    output logic [boxds_pkg::COORD_W-1:0]     out_x,
    output logic [boxds_pkg::COORD_W-1:0]     out_y
);
    import boxds_pkg::*;

    // Command and status between the sequencer and the datapath.
    // The sequencer accepts a transaction only when idle; a result waits in
    // the output register, so the next pixels keep flowing while it is held.
    cmd_t    cmd;
    status_t status;

    boxds_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath: hold the horizontal sum, merge it with the line store entry
    // of the block column, then divide the block total by scale squared.
    boxds_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .out_x     (out_x),
        .out_y     (out_y)
    );

endmodule

// ----- hw/rtl/boxds_ctrl.sv -----
// Sequencer for the box average downscaler: accept, merge, divide, output.
// Depends on boxds_pkg for the command and status structs.
`timescale 1ns / 1ps

module boxds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  boxds_pkg::status_t status,
    output boxds_pkg::cmd_t    cmd
);
    import boxds_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MERGE = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        pixel_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                pixel_stall = 1'b0;
                if (pixel_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.block_done)
                    begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_MERGE:
            begin
                cmd.merge = 1'b1;
                step_next = '0;
                state_next = status.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(Q_BITS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- hw/rtl/boxds_datapath.sv -----
// Datapath of the box average downscaler: counters, accumulators, line store,
// restoring divider and output register. Depends on boxds_pkg.
`timescale 1ns / 1ps

module boxds_datapath #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  boxds_pkg::cmd_t                     cmd,
    output boxds_pkg::status_t                  status,
    input  logic                                cfg_we,
    input  logic [boxds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [boxds_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [boxds_pkg::PIX_W-1:0]         pixel,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [boxds_pkg::PIX_W-1:0]         out_pixel,
    output logic [boxds_pkg::COORD_W-1:0]       out_x,
    output logic [boxds_pkg::COORD_W-1:0]       out_y
);
    import boxds_pkg::*;

    localparam int SCL_BITS = $clog2(MAX_SCALE + 1);
    localparam int SCW  = (SCL_BITS > SCALE_W) ? SCL_BITS : SCALE_W;
    localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
    localparam int WCW  = (WID_BITS > DIM_W) ? WID_BITS : DIM_W;
    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int HSW  = $clog2(MAX_SCALE * 255 + 1);
    localparam int TSW  = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
    localparam int DW   = $clog2(MAX_SCALE * MAX_SCALE + 1);
    localparam int DSW  = DW + Q_BITS;

    // configuration
    logic [SCALE_W-1:0] scale_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               restart;

    // frame position
    logic [COLW-1:0]    col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [SCW-1:0]     cib_reg;
    logic [SCW-1:0]     rib_reg;
    logic [HSW-1:0]     hsum_reg;
    logic [COLW-1:0]    bc_reg;
    logic [COORD_W-1:0] band_reg;

    // per-block hold
    logic [HSW-1:0]     blk_sum_reg;
    logic [COLW-1:0]    bc_hold_reg;
    logic [COORD_W-1:0] by_hold_reg;
    logic               first_row_reg;
    logic               emit_reg;

    // line store
    logic [TSW-1:0]     line_mem [MAX_WIDTH];
    logic [TSW-1:0]     rd_data_reg;

    // divider
    logic [TSW-1:0]     rem_reg;
    logic [DSW-1:0]     dsh_reg;
    logic [Q_BITS-1:0]  quo_reg;

    // output slot
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pixel_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;

    logic [SCW-1:0]     s_eff;
    logic [WCW-1:0]     w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [DW-1:0]      sq;
    logic [HSW-1:0]     hsum_new;
    logic [SCW-1:0]     cib_inc;
    logic [SCW-1:0]     rib_inc;
    logic [WCW-1:0]     col_inc;
    logic [DIM_W-1:0]   row_inc;
    logic               blk;
    logic               row_end;
    logic               band_end;
    logic               frame_end;
    logic [TSW-1:0]     total;
    logic               take;

    // clamp registers to their legal ranges
    always_comb
    begin
        if (scale_reg == '0)
            s_eff = SCW'(1);
        else if (SCW'(scale_reg) > SCW'(MAX_SCALE))
            s_eff = SCW'(MAX_SCALE);
        else
            s_eff = SCW'(scale_reg);

        if (width_reg == '0)
            w_eff = WCW'(1);
        else if (WCW'(width_reg) > WCW'(MAX_WIDTH))
            w_eff = WCW'(MAX_WIDTH);
        else
            w_eff = WCW'(width_reg);

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign sq        = DW'(s_eff) * DW'(s_eff);
    assign hsum_new  = hsum_reg + HSW'(pixel);
    assign cib_inc   = cib_reg + 1'b1;
    assign rib_inc   = rib_reg + 1'b1;
    assign col_inc   = WCW'(col_reg) + 1'b1;
    assign row_inc   = DIM_W'(row_reg) + 1'b1;
    assign blk       = (cib_inc >= s_eff);
    assign row_end   = (col_inc >= w_eff);
    assign band_end  = (rib_inc >= s_eff);
    assign frame_end = (row_inc >= h_eff);
    assign total     = first_row_reg ? TSW'(blk_sum_reg) : rd_data_reg + TSW'(blk_sum_reg);
    assign take      = out_valid_reg && !out_stall;
    assign restart   = cfg_we && (cfg_index == REG_SCALE || cfg_index == REG_WIDTH
                                  || cfg_index == REG_HEIGHT);

    assign status.block_done = blk;
    assign status.emit       = emit_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // advance the frame position on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            hsum_reg <= '0;
            bc_reg   <= '0;
            band_reg <= '0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            hsum_reg <= '0;
            bc_reg   <= '0;
            band_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (row_end)
            begin
                col_reg  <= '0;
                cib_reg  <= '0;
                hsum_reg <= '0;
                bc_reg   <= '0;
                if (frame_end)
                begin
                    row_reg  <= '0;
                    rib_reg  <= '0;
                    band_reg <= '0;
                end
                else
                begin
                    row_reg <= row_inc[COORD_W-1:0];
                    if (band_end)
                    begin
                        rib_reg  <= '0;
                        band_reg <= band_reg + 1'b1;
                    end
                    else
                    begin
                        rib_reg <= rib_inc;
                    end
                end
            end
            else
            begin
                col_reg <= col_inc[COLW-1:0];
                if (blk)
                begin
                    cib_reg  <= '0;
                    hsum_reg <= '0;
                    bc_reg   <= bc_reg + 1'b1;
                end
                else
                begin
                    cib_reg  <= cib_inc;
                    hsum_reg <= hsum_new;
                end
            end
        end
    end

    // hold what the merge step needs from the completing pixel
    always_ff @(posedge clk)
    begin
        if (cmd.accept && blk)
        begin
            blk_sum_reg   <= hsum_new;
            bc_hold_reg   <= bc_reg;
            by_hold_reg   <= band_reg;
            first_row_reg <= (rib_reg == '0);
            emit_reg      <= band_end;
        end
    end

    // line store: registered read at the current block column every cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= line_mem[bc_reg];
        if (cmd.merge)
        begin
            line_mem[bc_hold_reg] <= total;
        end
    end

    // restoring divider, one quotient bit per step, most significant first
    always_ff @(posedge clk)
    begin
        if (cmd.merge)
        begin
            rem_reg <= total;
            dsh_reg <= DSW'(sq) << (Q_BITS - 1);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (DSW'(rem_reg) >= dsh_reg)
            begin
                rem_reg <= rem_reg - TSW'(dsh_reg);
                quo_reg <= {quo_reg[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[Q_BITS-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pixel_reg <= quo_reg;
            out_x_reg     <= COORD_W'(bc_hold_reg);
            out_y_reg     <= by_hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

endmodule
